// ----- rtl/core/dtti_pkg.sv -----
package dtti_pkg;

    localparam int RESULT_BITS = 32;
    localparam int CHAR_BITS = 8;
    localparam int ERR_BITS = 2;
    localparam int PROD_BITS = RESULT_BITS + 4;

    localparam logic [2:0] PH_WS     = 3'd0;
    localparam logic [2:0] PH_SIGN   = 3'd1;
    localparam logic [2:0] PH_DIGITS = 3'd2;
    localparam logic [2:0] PH_TAIL   = 3'd3;
    localparam logic [2:0] PH_FROZEN = 3'd4;

    localparam logic [CHAR_BITS-1:0] CH_END   = 8'd0;
    localparam logic [CHAR_BITS-1:0] CH_TAB   = 8'd9;
    localparam logic [CHAR_BITS-1:0] CH_CR    = 8'd13;
    localparam logic [CHAR_BITS-1:0] CH_SPACE = 8'd32;
    localparam logic [CHAR_BITS-1:0] CH_PLUS  = 8'd43;
    localparam logic [CHAR_BITS-1:0] CH_MINUS = 8'd45;
    localparam logic [CHAR_BITS-1:0] CH_ZERO  = 8'd48;
    localparam logic [CHAR_BITS-1:0] CH_NINE  = 8'd57;

    localparam logic [PROD_BITS-1:0] POS_LIMIT =
        PROD_BITS'((64'd1 << (RESULT_BITS - 1)) - 64'd1);
    localparam logic [PROD_BITS-1:0] NEG_LIMIT =
        PROD_BITS'(64'd1 << (RESULT_BITS - 1));

    localparam int OUT_BYTES = (RESULT_BITS + ERR_BITS + 7) / 8;
    localparam int OUT_BITS = OUT_BYTES * 8;

    typedef struct packed {
        logic [ERR_BITS-1:0]    error_count;
        logic [RESULT_BITS-1:0] value;
    } dtti_result_t;

endpackage

// ----- rtl/core/decimal_text_to_int32.sv -----
// Result: the zero byte waits in the input register until the result slot is
// free, is then consumed, and the result is registered on the master side.
// Throughput: one character per cycle; the input stalls only while a result
// is held and not taken, and the next string's terminator needs that slot.
// Reset: synchronous, active low; clears the parse state and both valid flags.
module decimal_text_to_int32
    import dtti_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [CHAR_BITS-1:0] s_tdata,   // [7:0] char_code
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [OUT_BITS-1:0]  m_tdata    // [31:0] value, [33:32] error_count
);

    logic                 in_valid_reg;
    logic [CHAR_BITS-1:0] in_char_reg;
    logic                 m_valid_reg;
    dtti_result_t         m_data_reg;
    dtti_result_t         result;
    logic                 is_term;
    logic                 out_free;
    logic                 consume;

    assign is_term  = (in_char_reg == CH_END);
    assign out_free = !m_valid_reg || m_tready;
    assign consume  = in_valid_reg && (!is_term || out_free);
    assign s_tready = !in_valid_reg || consume;

    dtti_parse u_parse (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (consume),
        .char_code (in_char_reg),
        .result    (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (consume) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_char_reg <= s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (consume && is_term) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (consume && is_term) begin
            m_data_reg <= result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_BITS'(m_data_reg);

    // A held character that cannot advance stays in the input register.
    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !consume) |=> in_valid_reg)
        else $error("stalled input character was dropped");

    // The input side only pushes back while a character is held.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> in_valid_reg)
        else $error("input not ready with empty input register");

    // A consumed terminator always yields a result in the next cycle.
    a_term_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (consume && is_term) |=> m_tvalid)
        else $error("terminator consumed without a result");

endmodule

// ----- rtl/core/dtti_parse.sv -----
module dtti_parse
    import dtti_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step_en,
    input  logic [CHAR_BITS-1:0] char_code,
    output dtti_result_t         result
);

    logic [2:0]             phase_reg, phase_next;
    logic                   negative_reg, negative_next;
    logic [RESULT_BITS-1:0] acc_reg, acc_next;
    logic [1:0]             sign_cnt_reg, sign_cnt_next;
    logic                   bad_reg, bad_next;
    logic                   missing_reg, missing_next;
    logic                   junk_reg, junk_next;
    logic                   ovf_reg, ovf_next;

    logic                   is_ws, is_dig, is_sign, is_end;
    logic [PROD_BITS-1:0]   prod;
    logic [PROD_BITS-1:0]   limit;
    logic                   digit_ovf;
    logic                   fault_a, fault_b, fault_c;
    logic [ERR_BITS-1:0]    errs;

    assign is_end  = (char_code == CH_END);
    assign is_ws   = (char_code == CH_SPACE) || (char_code >= CH_TAB && char_code <= CH_CR);
    assign is_dig  = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
    assign is_sign = (char_code == CH_PLUS) || (char_code == CH_MINUS);

    // The low nibble of an ASCII digit is its value.
    assign prod = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
                + {{(PROD_BITS-4){1'b0}}, char_code[3:0]};
    assign limit = negative_reg ? NEG_LIMIT : POS_LIMIT;
    assign digit_ovf = (prod > limit);

    assign fault_a = bad_reg || sign_cnt_reg[1];
    assign fault_b = missing_reg || (phase_reg == PH_WS) || (phase_reg == PH_SIGN);
    assign fault_c = junk_reg;
    assign errs = ovf_reg ? {1'b0, fault_a}
                          : ERR_BITS'({1'b0, fault_a} + {1'b0, fault_b} + {1'b0, fault_c});

    assign result.error_count = errs;
    assign result.value = ovf_reg ? (negative_reg ? '0 : '1)
                                  : (negative_reg ? (RESULT_BITS'(0) - acc_reg) : acc_reg);

    always_comb begin
        phase_next    = phase_reg;
        negative_next = negative_reg;
        acc_next      = acc_reg;
        sign_cnt_next = sign_cnt_reg;
        bad_next      = bad_reg;
        missing_next  = missing_reg;
        junk_next     = junk_reg;
        ovf_next      = ovf_reg;
        if (is_end) begin
            phase_next    = PH_WS;
            negative_next = 1'b0;
            acc_next      = '0;
            sign_cnt_next = 2'd0;
            bad_next      = 1'b0;
            missing_next  = 1'b0;
            junk_next     = 1'b0;
            ovf_next      = 1'b0;
        end else begin
            if (is_sign) begin
                if (!sign_cnt_reg[1]) begin
                    sign_cnt_next = sign_cnt_reg + 2'd1;
                end
            end else if (!is_ws && !is_dig) begin
                bad_next = 1'b1;
            end
            case (phase_reg)
                PH_WS, PH_SIGN, PH_DIGITS: begin
                    if (is_dig) begin
                        if (digit_ovf) begin
                            ovf_next   = 1'b1;
                            phase_next = PH_FROZEN;
                        end else begin
                            acc_next   = prod[RESULT_BITS-1:0];
                            phase_next = PH_DIGITS;
                        end
                    end else if (phase_reg == PH_WS && is_ws) begin
                        phase_next = PH_WS;
                    end else if (phase_reg == PH_WS && is_sign) begin
                        negative_next = (char_code == CH_MINUS);
                        phase_next    = PH_SIGN;
                    end else begin
                        if (phase_reg != PH_DIGITS) begin
                            missing_next = 1'b1;
                        end
                        junk_next  = 1'b1;
                        phase_next = PH_TAIL;
                    end
                end
                default: begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_WS;
            negative_reg <= 1'b0;
            acc_reg      <= '0;
            sign_cnt_reg <= 2'd0;
            bad_reg      <= 1'b0;
            missing_reg  <= 1'b0;
            junk_reg     <= 1'b0;
            ovf_reg      <= 1'b0;
        end else if (step_en) begin
            phase_reg    <= phase_next;
            negative_reg <= negative_next;
            acc_reg      <= acc_next;
            sign_cnt_reg <= sign_cnt_next;
            bad_reg      <= bad_next;
            missing_reg  <= missing_next;
            junk_reg     <= junk_next;
            ovf_reg      <= ovf_next;
        end
    end

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
    import dtti_pkg::*;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [CHAR_BITS-1:0] s_tdata = '0;     // [7:0] char_code
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [OUT_BITS-1:0]  m_tdata;          // [31:0] value, [33:32] error_count

    decimal_text_to_int32 dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    int gap_pct = 0;
    int stall_pct = 0;
    int hold_left = 0;
    int fault_count = 0;
    int chars_sent = 0;
    int strings_sent = 0;
    int results_seen = 0;
    int overflow_results = 0;
    int faulty_results = 0;

    // Parser state mirrored by the scoreboard.
    logic [2:0]  scan_phase = PH_WS;
    logic        scan_negative = 1'b0;
    logic [63:0] scan_acc = '0;
    logic [1:0]  scan_signs = '0;
    logic        scan_bad = 1'b0;
    logic        scan_missing = 1'b0;
    logic        scan_junk = 1'b0;
    logic        scan_overflow = 1'b0;

    dtti_result_t awaited_numbers[$];

    task automatic report_mismatch(string what, logic [63:0] exp_v, logic [63:0] got_v);
        fault_count++;
        if (fault_count <= 40) begin
            $display("ERROR at %0t: %s, wanted %0h, got %0h", $realtime, what, exp_v, got_v);
        end
    endtask

    function automatic void clear_scan();
        scan_phase = PH_WS;
        scan_negative = 1'b0;
        scan_acc = '0;
        scan_signs = '0;
        scan_bad = 1'b0;
        scan_missing = 1'b0;
        scan_junk = 1'b0;
        scan_overflow = 1'b0;
    endfunction

    function automatic void scan_digit(logic [CHAR_BITS-1:0] c);
        logic [63:0] digit;
        logic [63:0] limit;
        digit = 64'(c - CH_ZERO);
        limit = scan_negative ? 64'(NEG_LIMIT) : 64'(POS_LIMIT);
        if (scan_acc > (limit - digit) / 64'd10) begin
            scan_overflow = 1'b1;
            scan_phase = PH_FROZEN;
        end else begin
            scan_acc = scan_acc * 64'd10 + digit;
            scan_phase = PH_DIGITS;
        end
    endfunction

    function automatic void parse_char(logic [CHAR_BITS-1:0] c);
        logic         is_blank;
        logic         is_digit;
        logic         is_sign;
        int           errs;
        dtti_result_t number;
        is_blank = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
        is_sign = (c == CH_PLUS) || (c == CH_MINUS);
        if (c != CH_END) begin
            if (is_sign) begin
                if (scan_signs < 2'd2) scan_signs = scan_signs + 2'd1;
            end else if (!is_blank && !is_digit) begin
                scan_bad = 1'b1;
            end
            case (scan_phase)
                PH_WS: begin
                    if (is_sign) begin
                        scan_negative = (c == CH_MINUS);
                        scan_phase = PH_SIGN;
                    end else if (is_digit) begin
                        scan_digit(c);
                    end else if (!is_blank) begin
                        scan_missing = 1'b1;
                        scan_junk = 1'b1;
                        scan_phase = PH_TAIL;
                    end
                end
                PH_SIGN: begin
                    if (is_digit) begin
                        scan_digit(c);
                    end else begin
                        scan_missing = 1'b1;
                        scan_junk = 1'b1;
                        scan_phase = PH_TAIL;
                    end
                end
                PH_DIGITS: begin
                    if (is_digit) begin
                        scan_digit(c);
                    end else begin
                        scan_junk = 1'b1;
                        scan_phase = PH_TAIL;
                    end
                end
                default: ;
            endcase
        end else begin
            if (scan_phase == PH_WS || scan_phase == PH_SIGN) scan_missing = 1'b1;
            errs = (scan_bad || scan_signs >= 2'd2) ? 1 : 0;
            if (scan_overflow) begin
                number.value = scan_negative ? '0 : '1;
                overflow_results++;
            end else begin
                errs += int'(scan_missing) + int'(scan_junk);
                number.value = scan_negative ? RESULT_BITS'(64'd0 - scan_acc)
                                             : RESULT_BITS'(scan_acc);
            end
            number.error_count = ERR_BITS'(errs);
            if (errs != 0) faulty_results++;
            awaited_numbers.push_back(number);
            clear_scan();
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        dtti_result_t got;
        dtti_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = dtti_result_t'(m_tdata[RESULT_BITS+ERR_BITS-1:0]);
            results_seen++;
            if (awaited_numbers.size() == 0) begin
                report_mismatch("result with nothing awaited", '0, 64'(got));
            end else begin
                want = awaited_numbers.pop_front();
                if (got.value !== want.value)
                    report_mismatch("value", 64'(want.value), 64'(got.value));
                if (got.error_count !== want.error_count)
                    report_mismatch("error_count", 64'(want.error_count),
                                    64'(got.error_count));
            end
        end
    end

    task automatic send_char(logic [CHAR_BITS-1:0] c);
        while ($urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= c;
        do @(posedge aclk); while (!s_tready);
        chars_sent++;
        parse_char(c);
    endtask

    task automatic send_text(logic [CHAR_BITS-1:0] text[$]);
        foreach (text[i]) send_char(text[i]);
        strings_sent++;
    endtask

    task automatic send_string(string s);
        logic [CHAR_BITS-1:0] text[$];
        for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
        text.push_back(CH_END);
        send_text(text);
    endtask

    function automatic void append_digits(ref logic [CHAR_BITS-1:0] text[$],
                                          input logic [63:0] mag);
        logic [CHAR_BITS-1:0] rev[$];
        do begin
            rev.push_front(CH_ZERO + CHAR_BITS'(mag % 64'd10));
            mag = mag / 64'd10;
        end while (mag != 0);
        foreach (rev[i]) text.push_back(rev[i]);
    endfunction

    function automatic logic [CHAR_BITS-1:0] blank_char();
        int n;
        n = $urandom_range(5);
        return (n == 5) ? CH_SPACE : CH_TAB + CHAR_BITS'(n);
    endfunction

    function automatic logic [CHAR_BITS-1:0] any_char();
        return CHAR_BITS'($urandom_range(255, 1));
    endfunction

    // Mostly well-formed numbers, some broken ones, and some raw noise.
    function automatic void make_random_text(ref logic [CHAR_BITS-1:0] text[$]);
        int kind;
        int flaw;
        kind = $urandom_range(99);
        flaw = $urandom_range(2);
        if (kind < 85) begin
            repeat ($urandom_range(3)) text.push_back(blank_char());
            if (kind >= 70 && flaw == 0)
                text.push_back($urandom_range(1) ? CH_PLUS : CH_MINUS);
            case ($urandom_range(2))
                1: text.push_back(CH_PLUS);
                2: text.push_back(CH_MINUS);
                default: ;
            endcase
            if (!(kind >= 70 && flaw == 1)) begin
                case ($urandom_range(2))
                    0: append_digits(text, 64'($urandom_range(999)));
                    1: append_digits(text, 64'($urandom));
                    default: begin
                        repeat ($urandom_range(12, 1))
                            text.push_back(CH_ZERO + CHAR_BITS'($urandom_range(9)));
                    end
                endcase
            end
            if (kind >= 70 && flaw != 0)
                repeat ($urandom_range(3, 1)) text.push_back(any_char());
        end else begin
            repeat ($urandom_range(6)) text.push_back(any_char());
        end
        text.push_back(CH_END);
    endfunction

    task automatic test_special_cases();
        gap_pct = 0;
        stall_pct = 0;
        send_string("");
        send_string("\011\012\013\014\015 ");
        send_string("+");
        send_string("-+");
        send_string("\377\2005");
        send_string("09 ");
        send_string(" +42");
    endtask

    // Magnitudes around both ends of the signed range, with overflow tails.
    task automatic test_range_edges();
        logic [CHAR_BITS-1:0] text[$];
        logic [63:0]          mag;
        for (int neg = 0; neg < 2; neg++) begin
            for (int off = -2; off <= 2; off++) begin
                text.delete();
                repeat ($urandom_range(2)) text.push_back(blank_char());
                if (neg != 0) text.push_back(CH_MINUS);
                else if ($urandom_range(1)) text.push_back(CH_PLUS);
                repeat ($urandom_range(2)) text.push_back(CH_ZERO);
                mag = (neg != 0) ? 64'(NEG_LIMIT) : 64'(POS_LIMIT);
                append_digits(text, 64'(longint'(mag) + off));
                text.push_back(CH_END);
                send_text(text);
            end
        end
        for (int neg = 0; neg < 2; neg++) begin
            text.delete();
            if (neg != 0) text.push_back(CH_MINUS);
            repeat (14) text.push_back(CH_ZERO + CHAR_BITS'($urandom_range(9, 1)));
            text.push_back(any_char());
            text.push_back(CH_PLUS);
            text.push_back(CH_END);
            send_text(text);
        end
    endtask

    // The receiver holds off while short requests keep coming, so the result
    // slot fills and the input has to stall.
    task automatic test_back_pressure();
        logic [CHAR_BITS-1:0] text[$];
        gap_pct = 0;
        stall_pct = 0;
        hold_left <= 300;
        repeat (30) begin
            text.delete();
            text.push_back(CH_ZERO + CHAR_BITS'($urandom_range(9)));
            text.push_back(CH_END);
            send_text(text);
        end
    endtask

    task automatic test_random_text(int gap, int stall, int char_goal);
        logic [CHAR_BITS-1:0] text[$];
        int                   first;
        gap_pct = gap;
        stall_pct = stall;
        first = chars_sent;
        while (chars_sent - first < char_goal) begin
            text.delete();
            make_random_text(text);
            send_text(text);
        end
    endtask

    task automatic finish_run();
        int waited;
        waited = 0;
        s_tvalid <= 1'b0;
        gap_pct = 0;
        stall_pct = 0;
        while (awaited_numbers.size() != 0 && waited < 20000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (4) @(posedge aclk);
        if (awaited_numbers.size() != 0)
            report_mismatch("results never delivered", 64'(awaited_numbers.size()), '0);
        $display("Sent %0d characters in %0d strings; checked %0d results.",
                 chars_sent, strings_sent, results_seen);
        $display("Of those, %0d overflowed and %0d carried format faults.",
                 overflow_results, faulty_results);
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_special_cases();
        test_range_edges();
        test_back_pressure();
        test_random_text(0, 0, 320);
        test_random_text(50, 0, 320);
        test_random_text(0, 50, 320);
        test_random_text(32, 32, 320);
        finish_run();
        if (fault_count == 0) begin
            $display("decimal_text_to_int32: match");
        end else begin
            $display("decimal_text_to_int32: mismatch");
        end
        $finish;
    end

    initial begin
        #2400000;
        $display("Run timed out.");
        $display("decimal_text_to_int32: mismatch");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/dtti_pkg.sv
rtl/core/dtti_parse.sv
rtl/core/decimal_text_to_int32.sv
tb/tb_top.sv
